/* sv/chtbl_pkg.sv */
// Shared types, field widths and codes of the chained hash table.
package chtbl_pkg;

  localparam int CFG_W = 7;
  localparam int VAL_W = 32;
  localparam int SEL_W = 6;
  localparam int OP_W  = 2;
  localparam int ST_W  = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_LISTED    = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_FREAD, S_FCHK, S_RD, S_CHK, S_SHRD, S_SHWR, S_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [CFG_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] entry;
    logic [SEL_W-1:0] bucket;
    logic             last;
  } result_t;

endpackage

/* sv/chtbl_mod.sv */
// Iterative 32-bit modulo by the bucket count, one quotient bit per cycle.
module chtbl_mod (
  input  logic              clk,
  input  logic              rst_n,
  input  chtbl_pkg::mod_req_t req,
  output chtbl_pkg::mod_rsp_t rsp
);
  import chtbl_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [VAL_W-1:0] dvd_r, dvd_nxt;
  logic [CFG_W-1:0] dvs_r, dvs_nxt;
  logic [CFG_W-1:0] rem_r, rem_nxt;
  logic [CFG_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[VAL_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd31;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = CFG_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = CFG_W'(trial);
      end
      dvd_nxt = {dvd_r[VAL_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

/* sv/chtbl_core.sv */
// Table controller: fill-count and entry memories with the insert, remove and list sequencer.
module chtbl_core #(
  parameter int MAX_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [chtbl_pkg::OP_W-1:0]    req_op,
  input  logic [chtbl_pkg::VAL_W-1:0]   req_value,
  input  logic [chtbl_pkg::SEL_W-1:0]   req_sel,
  input  logic [chtbl_pkg::CFG_W-1:0]   divisor,
  output chtbl_pkg::mod_req_t           mod_req,
  input  chtbl_pkg::mod_rsp_t           mod_rsp,
  output logic                          res_valid,
  input  logic                          res_ready,
  output chtbl_pkg::result_t            res
);
  import chtbl_pkg::*;

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam int XW = FW + 1;
  localparam int ENT_DEPTH = MAX_BUCKETS * (2 ** SW);

  logic [VAL_W-1:0] ent_mem [ENT_DEPTH];
  logic [FW-1:0]    fill_mem [MAX_BUCKETS];

  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [BW-1:0]    bkt_r, bkt_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic [BW-1:0]    clr_r, clr_nxt;
  logic             more_r, more_nxt;
  result_t          res_r, res_nxt;

  logic [VAL_W-1:0]  ent_rdata_r;
  logic [FW-1:0]     fill_rdata_r;
  logic [BW+SW-1:0]  ent_raddr, ent_waddr;
  logic              ent_we;
  logic [VAL_W-1:0]  ent_wdata;
  logic [BW-1:0]     fill_raddr, fill_waddr;
  logic              fill_we;
  logic [FW-1:0]     fill_wdata;

  logic [31:0]       sel_w, rem_w, bkt_w;
  logic [XW-1:0]     idx_x, fill_x;
  logic              sel_ok;

  assign sel_w  = 32'(req_sel);
  assign rem_w  = 32'(mod_rsp.rem);
  assign bkt_w  = 32'(bkt_r);
  assign sel_ok = sel_w < MAX_BUCKETS;
  assign idx_x  = XW'(idx_r);
  assign fill_x = XW'(fill_r);

  // next state and working registers
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    bkt_nxt   = bkt_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    clr_nxt   = clr_r;
    more_nxt  = more_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == MAX_BUCKETS - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          op_nxt   = req_op;
          val_nxt  = req_value;
          bkt_nxt  = sel_w[BW-1:0];
          more_nxt = 1'b0;
          if (req_op == OP_INSERT || req_op == OP_REMOVE) begin
            state_nxt = S_HASH;
          end else if (req_op == OP_LIST) begin
            if (sel_ok) begin
              state_nxt = S_FREAD;
            end else begin
              res_nxt   = '{status: ST_EMPTY, entry: '0, bucket: req_sel, last: 1'b1};
              state_nxt = S_OUT;
            end
          end
        end
      end
      S_HASH: begin
        if (mod_rsp.done) begin
          bkt_nxt   = rem_w[BW-1:0];
          state_nxt = S_FREAD;
        end
      end
      S_FREAD: state_nxt = S_FCHK;
      S_FCHK: begin
        fill_nxt = fill_rdata_r;
        idx_nxt  = '0;
        res_nxt  = '{status: ST_DONE, entry: val_r, bucket: bkt_w[SEL_W-1:0], last: 1'b1};
        if (op_r == OP_INSERT) begin
          if (32'(fill_rdata_r) >= BUCKET_DEPTH) res_nxt.status = ST_FULL;
          state_nxt = S_OUT;
        end else if (fill_rdata_r == '0) begin
          if (op_r == OP_LIST) begin
            res_nxt.status = ST_EMPTY;
            res_nxt.entry  = '0;
          end else begin
            res_nxt.status = ST_NOT_FOUND;
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (op_r == OP_LIST) begin
          res_nxt.status = ST_LISTED;
          res_nxt.entry  = ent_rdata_r;
          res_nxt.last   = (idx_x + 1'b1) == fill_x;
          more_nxt       = (idx_x + 1'b1) != fill_x;
          state_nxt      = S_OUT;
        end else if (ent_rdata_r == val_r) begin
          if ((idx_x + 1'b1) < fill_x) begin
            state_nxt = S_SHRD;
          end else begin
            state_nxt = S_OUT;
          end
        end else if ((idx_x + 1'b1) < fill_x) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_OUT;
        end
      end
      S_SHRD: state_nxt = S_SHWR;
      S_SHWR: begin
        idx_nxt = idx_r + 1'b1;
        if ((idx_x + 2'd2) < fill_x) begin
          state_nxt = S_SHRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          if (more_r) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory controls and handshakes
  always_comb begin
    req_ready    = 1'b0;
    mod_req      = '{start: 1'b0, dividend: req_value, divisor: divisor};
    fill_raddr   = bkt_r;
    fill_we      = 1'b0;
    fill_waddr   = bkt_r;
    fill_wdata   = fill_r - 1'b1;
    ent_raddr    = {bkt_r, idx_r};
    ent_we       = 1'b0;
    ent_waddr    = {bkt_r, idx_r};
    ent_wdata    = ent_rdata_r;
    res_valid    = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        fill_wdata = '0;
      end
      S_IDLE: begin
        req_ready     = 1'b1;
        mod_req.start = req_valid && (req_op == OP_INSERT || req_op == OP_REMOVE);
      end
      S_FCHK: begin
        if (op_r == OP_INSERT && 32'(fill_rdata_r) < BUCKET_DEPTH) begin
          ent_we     = 1'b1;
          ent_waddr  = {bkt_r, fill_rdata_r[SW-1:0]};
          ent_wdata  = val_r;
          fill_we    = 1'b1;
          fill_wdata = fill_rdata_r + 1'b1;
        end
      end
      S_CHK: begin
        // drop the last slot when the match has nothing behind it
        if (op_r == OP_REMOVE && ent_rdata_r == val_r && !((idx_x + 1'b1) < fill_x)) begin
          fill_we = 1'b1;
        end
      end
      S_SHRD: ent_raddr = {bkt_r, idx_r + 1'b1};
      S_SHWR: begin
        ent_we = 1'b1;
        if (!((idx_x + 2'd2) < fill_x)) fill_we = 1'b1;
      end
      S_OUT: res_valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    bkt_r  <= bkt_nxt;
    fill_r <= fill_nxt;
    idx_r  <= idx_nxt;
    more_r <= more_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rdata_r <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  assign res = res_r;

endmodule

/* sv/chained_hash_table.sv */
// Top level of the chained hash table: bucket-count register, modulo unit and table controller.
// One request at a time. After reset the block sweeps the fill-count memory, clearing
// every bucket's count, with in_tready low. Insert and remove first hash the value in
// the bit-serial modulo unit, then read the bucket's fill count; insert then writes and
// reports. Remove scans the entries one at a time through the entry memory's single
// read port and closes the gap by moving each later entry down one slot. List skips
// the modulo and reads the bucket's entries one at a time, each result held until
// accepted. The next request is taken in the cycle after the final result is accepted.
module chained_hash_table #(
  parameter int MAX_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,     // num_buckets
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // value[31:0], bucket_sel[37:32], zero pad
  input  logic [1:0]  in_tuser,     // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // entry[31:0], bucket[37:32], zero pad
  output logic [2:0]  out_tuser,    // status
  output logic        out_tlast
);
  import chtbl_pkg::*;

  logic [CFG_W-1:0] nbkt_r, nbkt_nxt;
  logic [CFG_W-1:0] divisor;
  mod_req_t         mod_req;
  mod_rsp_t         mod_rsp;
  result_t          res;

  assign cfg_ready = 1'b1;
  assign nbkt_nxt  = (cfg_valid) ? cfg_data : nbkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbkt_r <= 7'd64;
    end else begin
      nbkt_r <= nbkt_nxt;
    end
  end

  // zero acts as one; clamp to the table size
  always_comb begin
    if (nbkt_r == '0) begin
      divisor = 7'd1;
    end else if (32'(nbkt_r) > MAX_BUCKETS) begin
      divisor = CFG_W'(MAX_BUCKETS);
    end else begin
      divisor = nbkt_r;
    end
  end

  chtbl_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mod_req),
    .rsp     (mod_rsp)
  );

  chtbl_core #(
    .MAX_BUCKETS  (MAX_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_op    (in_tuser),
    .req_value (in_tdata[31:0]),
    .req_sel   (in_tdata[37:32]),
    .divisor   (divisor),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {2'b00, res.bucket, res.entry};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

/* sv/chtbl_checker.sv */
// Port-level checker for the chained hash table, bound to the top level.
module chtbl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import chtbl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != OP_UNUSED |=> !in_tready)
    else $error("request taken while another is in progress");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("result pending while idle");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EMPTY |-> out_tlast && out_tdata[31:0] == 32'd0)
    else $error("empty bucket report malformed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_LISTED |-> out_tlast)
    else $error("single result without last");

endmodule

bind chained_hash_table chtbl_checker u_chtbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

/* tb/tb_chained_hash_table.sv */
// Self-checking testbench for the chained hash table: predicts results and checks each result.
module tb_chained_hash_table;
  timeunit 1ns;
  timeprecision 1ps;
  import chtbl_pkg::*;

  localparam int NBKT  = 64;
  localparam int DEPTH = 8;
  localparam int WDOG  = 20000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [SEL_W-1:0] sel;
  } request_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [6:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  chained_hash_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow table
  logic [VAL_W-1:0] tbl_store [NBKT][DEPTH];
  int unsigned      tbl_fill  [NBKT];
  logic [6:0]       bucket_cnt;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       mismatches;
  int       idle_cycles;
  bit       hold_off;
  int       hold_cnt;
  int       gap_cnt;
  logic     in_acc_r;

  function automatic void push_result(logic [ST_W-1:0] st, logic [VAL_W-1:0] e,
                                      logic [SEL_W-1:0] b, logic l);
    result_t r;
    r.status = st; r.entry = e; r.bucket = b; r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_table(request_t rq);
    int unsigned n;
    int unsigned h;
    int unsigned f;
    int          hit;
    n = bucket_cnt;
    if (n == 0) n = 1;
    if (n > NBKT) n = NBKT;
    h = rq.value % n;
    f = tbl_fill[h];
    hit = -1;
    case (rq.op)
      OP_INSERT: begin
        if (f >= DEPTH) begin
          push_result(ST_FULL, rq.value, SEL_W'(h), 1'b1);
        end else begin
          tbl_store[h][f] = rq.value;
          tbl_fill[h] = f + 1;
          push_result(ST_DONE, rq.value, SEL_W'(h), 1'b1);
        end
      end
      OP_REMOVE: begin
        for (int i = 0; i < f; i++)
          if (hit < 0 && tbl_store[h][i] == rq.value) hit = i;
        if (hit < 0) begin
          push_result(ST_NOT_FOUND, rq.value, SEL_W'(h), 1'b1);
        end else begin
          for (int j = hit; j + 1 < f; j++) tbl_store[h][j] = tbl_store[h][j+1];
          tbl_fill[h] = f - 1;
          push_result(ST_DONE, rq.value, SEL_W'(h), 1'b1);
        end
      end
      OP_LIST: begin
        f = tbl_fill[rq.sel];
        if (f == 0) push_result(ST_EMPTY, '0, rq.sel, 1'b1);
        else
          for (int i = 0; i < f; i++)
            push_result(ST_LISTED, tbl_store[rq.sel][i], rq.sel, i + 1 == f);
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: hold the request until the last rising edge took it
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      gap_cnt   <= 0;
    end else if (!in_tvalid || in_acc_r) begin
      if (gap_cnt > 0) begin
        gap_cnt   <= gap_cnt - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0 && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, pending_reqs[0].sel, pending_reqs[0].value};
        in_tuser  <= pending_reqs[0].op;
      end else begin
        in_tvalid <= 1'b0;
        if ($urandom_range(0, 49) == 0) gap_cnt <= $urandom_range(10, 60);
      end
    end
  end

  // Account for accepted requests at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_acc_r <= 1'b0;
      for (int b = 0; b < NBKT; b++) tbl_fill[b] = 0;
    end else begin
      in_acc_r <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        request_t rq;
        rq = pending_reqs.pop_front();
        predict_table(rq);
      end
    end
  end

  // Receiver readiness; long stalls count down here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt   <= 0;
    end else if (hold_off) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: out_tready <= 1'b0;
        default: out_tready <= 1'b1;
      endcase
      if ($urandom_range(0, 99) == 0) hold_cnt <= $urandom_range(10, 60);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result status=%0d entry=%h", out_tuser,
                                       out_tdata[31:0]);
      end else begin
        result_t ex;
        ex = expected_results.pop_front();
        if (out_tuser !== ex.status || out_tdata[31:0] !== ex.entry ||
            out_tdata[37:32] !== ex.bucket || out_tlast !== ex.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d e=%h b=%0d l=%0d got st=%0d e=%h b=%0d l=%0d",
                     ex.status, ex.entry, ex.bucket, ex.last, out_tuser, out_tdata[31:0],
                     out_tdata[37:32], out_tlast);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG) begin
      $display("** chained_hash_table: FAILED **");
      $finish;
    end
  end

  task automatic add_req(logic [OP_W-1:0] op, logic [VAL_W-1:0] v, logic [SEL_W-1:0] s);
    request_t rq;
    rq.op = op; rq.value = v; rq.sel = s;
    pending_reqs.push_back(rq);
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    // op 3 leaves nothing to wait for; let the block settle
    repeat (80) @(posedge clk);
  endtask

  task automatic write_buckets(logic [6:0] n);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    bucket_cnt = n;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mostly small pool so that buckets fill up and removes hit
  function automatic logic [VAL_W-1:0] pick_value(int unsigned pool);
    case ($urandom_range(0, 3))
      0: return $urandom();
      default: return $urandom_range(0, pool);
    endcase
  endfunction

  task automatic random_phase(int count, int unsigned pool);
    logic [VAL_W-1:0] v;
    for (int i = 0; i < count; i++) begin
      v = pick_value(pool);
      case ($urandom_range(0, 19))
        0:               add_req(OP_UNUSED, $urandom(), SEL_W'($urandom()));
        1, 2, 3, 4:      add_req(OP_LIST, '0, $urandom_range(0, 7) == 0 ?
                                 SEL_W'($urandom()) : SEL_W'($urandom_range(0, 7)));
        5, 6, 7, 8, 9:   add_req(OP_REMOVE, v, SEL_W'($urandom()));
        default:         add_req(OP_INSERT, v, SEL_W'($urandom()));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    hold_off = 0;
    bucket_cnt = 7'd64;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: extremes, every op, full bucket, miss, empty bucket
    add_req(OP_LIST, '0, 6'd0);
    add_req(OP_REMOVE, 32'h0000_0005, 6'd0);
    add_req(OP_INSERT, 32'h8000_0000, 6'h3f);
    add_req(OP_INSERT, 32'h7fff_ffff, 6'd0);
    add_req(OP_INSERT, 32'hffff_ffff, 6'd0);
    add_req(OP_INSERT, 32'h0000_0000, 6'd0);
    for (int i = 0; i < 9; i++) add_req(OP_INSERT, 32'd3 + 64 * i, 6'd0);
    add_req(OP_LIST, '0, 6'd3);
    add_req(OP_REMOVE, 32'd3 + 64 * 4, 6'd0);
    add_req(OP_REMOVE, 32'd3 + 64 * 4, 6'd0);
    add_req(OP_LIST, '0, 6'd3);
    add_req(OP_UNUSED, 32'hffff_ffff, 6'h3f);
    add_req(OP_LIST, '0, 6'h3f);
    add_req(OP_LIST, '0, 6'h00);
    drain();

    // Long receiver hold-off while the sender keeps offering
    hold_off = 1;
    random_phase(12, 40);
    repeat (400) @(posedge clk);
    hold_off = 0;
    drain();

    write_buckets(7'd0);
    random_phase(40, 12);
    drain();
    write_buckets(7'd1);
    random_phase(30, 12);
    drain();
    write_buckets(7'd127);
    random_phase(60, 200);
    drain();
    write_buckets(7'd65);
    random_phase(40, 200);
    drain();
    write_buckets(7'd5);
    random_phase(70, 30);
    drain();
    write_buckets(7'd64);
    random_phase(60, 300);
    drain();
    write_buckets(7'h2a);
    random_phase(20, 100);
    drain();

    if (mismatches == 0)
      $display("** chained_hash_table: PASSED **");
    else
      $display("** chained_hash_table: FAILED **");
    $finish;
  end

endmodule
